### src/assert_macros.svh
// Assertion helpers shared by the list core modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/adll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adll_pkg
// Types and codes for the array-backed doubly linked list core.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int ADDR_W = 11;
  localparam int POS_W  = 10;
  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_POP_BACK   = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_READ       = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // request and response payloads
  typedef struct packed {
    logic [3:0]               command;
    logic [ADDR_W-1:0]        node_addr;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ADDR_W-1:0]        result_addr;
    logic signed [DATA_W-1:0] read_value;
    logic [ADDR_W-1:0]        prev_addr;
    logic [ADDR_W-1:0]        next_addr;
    logic [ADDR_W-1:0]        count;
    logic                     is_empty;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_ADDR,
    OP_READ_T,
    OP_SET_PUSHB,
    OP_SET_PUSHF,
    OP_SET_INS,
    OP_SET_T_BACK,
    OP_SET_T_FRONT,
    OP_SET_T_ADDR,
    OP_WR_NODE,
    OP_LINK,
    OP_UNLINK,
    OP_STEP,
    OP_REPORT,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t err;
    logic    clear;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       full;
    logic       empty;
    logic       addr_head;
    logic       addr_ok;
    logic       rd_live;
    logic       pos_bad;
    logic       walk_done;
  } dp_stat_t;

endpackage

### src/adll_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adll_stream_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface adll_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/adll_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adll_dp
// Node memories, sentinel links, allocation and count registers, and the
// response registers of the list core.
// ----------------------------------------------------------------------------
module adll_dp #(
  parameter int LIST_CAPACITY = 1024,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  adll_pkg::req_t    req_data,
  input  adll_pkg::dp_cmd_t cmd,
  output adll_pkg::dp_stat_t stat,
  output adll_pkg::rsp_t    rsp_data
);
  import adll_pkg::*;
`include "assert_macros.svh"

  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int LW = $clog2(LIST_CAPACITY + 2);
  localparam int CW = (LW > ADDR_W) ? LW : ADDR_W;
  localparam int SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam logic [LW-1:0] HEAD = LW'(LIST_CAPACITY);
  localparam logic [LW-1:0] TAIL = LW'(LIST_CAPACITY + 1);
  localparam logic [LW-1:0] CAPL = LW'(LIST_CAPACITY);

  // node memories
  logic [SW-1:0] value_mem [LIST_CAPACITY];
  logic [LW-1:0] prev_mem  [LIST_CAPACITY];
  logic [LW-1:0] next_mem  [LIST_CAPACITY];
  logic          live_mem  [LIST_CAPACITY];

  // request copy
  logic [3:0]        cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [POS_W-1:0]  pos_q;
  logic [SW-1:0]     val_q;

  // control registers
  logic [LW-1:0]    alloc;
  logic [LW-1:0]    count;
  logic [LW-1:0]    head_next;
  logic [LW-1:0]    tail_prev;
  logic [LW-1:0]    p, n, t;
  logic [POS_W-1:0] steps;

  // read data
  logic [SW-1:0] rd_value;
  logic [LW-1:0] rd_prev, rd_next;
  logic          rd_live;

  // response registers
  status_t       r_status;
  logic [LW-1:0] r_addr, r_prev, r_next;
  logic [SW-1:0] r_value;

  logic [AW-1:0] rd_idx;

  assign rd_idx = (cmd.op == OP_READ_ADDR) ? addr_q[AW-1:0] : t[AW-1:0];

  // memory reads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ_ADDR || cmd.op == OP_READ_T) begin
      rd_value <= value_mem[rd_idx];
      rd_prev  <= prev_mem[rd_idx];
      rd_next  <= next_mem[rd_idx];
      rd_live  <= live_mem[rd_idx];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_WR_NODE: begin
        value_mem[alloc[AW-1:0]] <= val_q;
        prev_mem[alloc[AW-1:0]]  <= p;
        next_mem[alloc[AW-1:0]]  <= n;
        live_mem[alloc[AW-1:0]]  <= 1'b1;
      end
      OP_LINK: begin
        if (p != HEAD) next_mem[p[AW-1:0]] <= alloc;
        if (n != TAIL) prev_mem[n[AW-1:0]] <= alloc;
      end
      OP_UNLINK: begin
        if (rd_prev != HEAD) next_mem[rd_prev[AW-1:0]] <= rd_next;
        if (rd_next != TAIL) prev_mem[rd_next[AW-1:0]] <= rd_prev;
        live_mem[t[AW-1:0]] <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // list control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc     <= '0;
      count     <= '0;
      head_next <= TAIL;
      tail_prev <= HEAD;
    end else begin
      if (cmd.clear) begin
        alloc     <= '0;
        count     <= '0;
        head_next <= TAIL;
        tail_prev <= HEAD;
      end else if (cmd.op == OP_LINK) begin
        alloc <= alloc + 1'b1;
        count <= count + 1'b1;
        if (p == HEAD) head_next <= alloc;
        if (n == TAIL) tail_prev <= alloc;
      end else if (cmd.op == OP_UNLINK) begin
        count <= count - 1'b1;
        if (rd_prev == HEAD) head_next <= rd_next;
        if (rd_next == TAIL) tail_prev <= rd_prev;
      end
    end
  end

  // working registers and response
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_q  <= req_data.command;
        addr_q <= req_data.node_addr;
        pos_q  <= req_data.position;
        val_q  <= req_data.value[SW-1:0];
        steps  <= '0;
      end
      OP_SET_PUSHB: begin
        p <= tail_prev;
        n <= TAIL;
      end
      OP_SET_PUSHF: begin
        p <= HEAD;
        n <= head_next;
      end
      OP_SET_INS: begin
        p <= LW'(addr_q);
        n <= rd_next;
      end
      OP_SET_T_BACK:  t <= tail_prev;
      OP_SET_T_FRONT: t <= head_next;
      OP_SET_T_ADDR:  t <= LW'(addr_q);
      OP_STEP: begin
        t     <= rd_next;
        steps <= steps + 1'b1;
      end
      OP_LINK: begin
        r_status <= ST_OK;
        r_addr   <= alloc;
        r_value  <= val_q;
        r_prev   <= p;
        r_next   <= n;
      end
      OP_UNLINK: begin
        r_status <= ST_OK;
        r_addr   <= rd_prev;
        r_value  <= rd_value;
        r_prev   <= rd_prev;
        r_next   <= rd_next;
      end
      OP_REPORT: begin
        r_status <= ST_OK;
        r_addr   <= t;
        r_value  <= rd_value;
        r_prev   <= rd_prev;
        r_next   <= rd_next;
      end
      OP_ERR: begin
        r_status <= cmd.err;
        r_addr   <= '0;
        r_value  <= '0;
        r_prev   <= '0;
        r_next   <= '0;
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  assign stat.cmd       = cmd_q;
  assign stat.full      = (alloc == CAPL);
  assign stat.empty     = (count == '0);
  assign stat.addr_head = (CW'(addr_q) == CW'(HEAD));
  assign stat.addr_ok   = (CW'(addr_q) < CW'(alloc));
  assign stat.rd_live   = rd_live;
  assign stat.pos_bad   = (32'(pos_q) >= 32'(count));
  assign stat.walk_done = (steps == pos_q);

  // response payload
  assign rsp_data.status      = r_status;
  assign rsp_data.result_addr = ADDR_W'(r_addr);
  assign rsp_data.read_value  = DATA_W'(r_value);
  assign rsp_data.prev_addr   = ADDR_W'(r_prev);
  assign rsp_data.next_addr   = ADDR_W'(r_next);
  assign rsp_data.count       = ADDR_W'(count);
  assign rsp_data.is_empty    = (count == '0);

  `ASSERT_ALWAYS(a_count_le_alloc, count <= alloc, "count exceeds allocated slots")
  `ASSERT_ALWAYS(a_alloc_le_cap, alloc <= CAPL, "allocation beyond capacity")
  `ASSERT_NEXT(a_link_count, cmd.op == OP_LINK, count == LW'($past(count) + 1'b1), "link count")
  `ASSERT_IMPLIES(a_empty_links, count == '0, head_next == TAIL && tail_prev == HEAD,
                  "empty list with dangling sentinel links")
endmodule

### src/adll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adll_ctrl
// Command sequencer: decodes each request and steps the datapath through
// its reads, link updates and list walk.
// ----------------------------------------------------------------------------
module adll_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  adll_pkg::dp_stat_t stat,
  output adll_pkg::dp_cmd_t  cmd
);
  import adll_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_CHK, S_LINK1, S_LINK2,
    S_READT, S_CHK, S_WALK, S_STEP, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.err    = ST_OK;
    cmd.clear  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        cmd.op     = OP_ERR;
        unique case (cmd_t'(stat.cmd))
          CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (stat.full) begin
              cmd.err = ST_FULL;
            end else begin
              cmd.op     = (cmd_t'(stat.cmd) == CMD_PUSH_BACK) ? OP_SET_PUSHB : OP_SET_PUSHF;
              state_next = S_LINK1;
            end
          end
          CMD_INSERT: begin
            priority if (stat.addr_head && stat.full) begin
              cmd.err = ST_FULL;
            end else if (stat.addr_head) begin
              cmd.op     = OP_SET_PUSHF;
              state_next = S_LINK1;
            end else if (!stat.addr_ok) begin
              cmd.err = ST_BAD;
            end else begin
              cmd.op     = OP_READ_ADDR;
              state_next = S_INS_CHK;
            end
          end
          CMD_POP_BACK, CMD_POP_FRONT: begin
            if (stat.empty) begin
              cmd.err = ST_EMPTY;
            end else begin
              cmd.op     = (cmd_t'(stat.cmd) == CMD_POP_BACK) ? OP_SET_T_BACK : OP_SET_T_FRONT;
              state_next = S_READT;
            end
          end
          CMD_ERASE: begin
            priority if (stat.empty) begin
              cmd.err = ST_EMPTY;
            end else if (!stat.addr_ok) begin
              cmd.err = ST_BAD;
            end else begin
              cmd.op     = OP_SET_T_ADDR;
              state_next = S_READT;
            end
          end
          CMD_READ: begin
            if (!stat.addr_ok) begin
              cmd.err = ST_BAD;
            end else begin
              cmd.op     = OP_SET_T_ADDR;
              state_next = S_READT;
            end
          end
          CMD_FIND: begin
            priority if (stat.empty) begin
              cmd.err = ST_EMPTY;
            end else if (stat.pos_bad) begin
              cmd.err = ST_BAD;
            end else begin
              cmd.op     = OP_SET_T_FRONT;
              state_next = S_WALK;
            end
          end
          CMD_CLEAR: cmd.clear = 1'b1;
          default: begin
          end
        endcase
      end
      // insert target read back: check it is linked and the list is not full
      S_INS_CHK: begin
        priority if (!stat.rd_live) begin
          cmd.op     = OP_ERR;
          cmd.err    = ST_BAD;
          state_next = S_DONE;
        end else if (stat.full) begin
          cmd.op     = OP_ERR;
          cmd.err    = ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SET_INS;
          state_next = S_LINK1;
        end
      end
      S_LINK1: begin
        cmd.op     = OP_WR_NODE;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        cmd.op     = OP_LINK;
        state_next = S_DONE;
      end
      S_READT: begin
        cmd.op     = OP_READ_T;
        state_next = S_CHK;
      end
      // node data is in; unlink, report or flag an error
      S_CHK: begin
        state_next = S_DONE;
        unique case (cmd_t'(stat.cmd))
          CMD_POP_BACK, CMD_POP_FRONT: cmd.op = OP_UNLINK;
          CMD_ERASE: begin
            cmd.op  = stat.rd_live ? OP_UNLINK : OP_ERR;
            cmd.err = ST_BAD;
          end
          CMD_READ: begin
            cmd.op  = stat.rd_live ? OP_REPORT : OP_ERR;
            cmd.err = ST_BAD;
          end
          CMD_FIND: cmd.op = OP_REPORT;
          default:  cmd.op = OP_ERR;
        endcase
      end
      // walk one link per read and step
      S_WALK: begin
        cmd.op     = OP_READ_T;
        state_next = stat.walk_done ? S_CHK : S_STEP;
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_WALK;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid), "request and response open together")
  `ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state == S_DECODE, "accept not decoded")
  `ASSERT_NEXT(a_hold_resp, out_valid && !out_ready, out_valid, "response dropped")
endmodule

### src/array_doubly_linked_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_core
// Doubly linked list in node memories with head/tail sentinels at
// LIST_CAPACITY and LIST_CAPACITY+1; slots come from a bump pointer.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken, worked through by the sequencer
// against single-port node memories with one registered read per cycle, and
// its response held until taken, then the next request is accepted. A
// find_position walk does one link read and one step per node walked. Clear
// and requests rejected at decode go straight from decode to the response;
// an insert can also be rejected after its target read.
// No clearing pass after reset: slot liveness is qualified by the bump pointer.
module array_doubly_linked_list_core #(
  parameter int LIST_CAPACITY = 1024,
  parameter int VALUE_WIDTH   = 32
) (
  input logic clk,
  input logic rst,
  adll_stream_if.sink   req,
  adll_stream_if.source rsp
);
  import adll_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  adll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  adll_dp #(
    .LIST_CAPACITY (LIST_CAPACITY),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .rsp_data (rsp.data)
  );
endmodule

### bench/adll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adll_checker
// Watches the request and response channels of the list core, keeps its own
// copy of the node store and links, works out each response and compares it
// field by field with what the core returns.
// ----------------------------------------------------------------------------
module adll_checker
  import adll_pkg::*;
#(
  parameter int CAP = 1024
) (
  input  logic   clk,
  input  logic   rst,
  adll_stream_if req_ch,
  adll_stream_if rsp_ch,
  output int     errors,
  output int     pending
);

  localparam logic [ADDR_W-1:0] HEAD = ADDR_W'(CAP);
  localparam logic [ADDR_W-1:0] TAIL = ADDR_W'(CAP + 1);
  localparam int                EXP_DEPTH = 16;

  // shadow list state
  logic signed [DATA_W-1:0] node_val [0:CAP-1];
  logic [ADDR_W-1:0]        prev_l   [0:CAP+1];
  logic [ADDR_W-1:0]        next_l   [0:CAP+1];
  logic                     live     [0:CAP-1];
  int                       alloc_ptr;
  int                       elems;

  // expected responses, oldest at exp_rd
  rsp_t exp_buf [0:EXP_DEPTH-1];
  int   exp_wr = 0;
  int   exp_rd = 0;

  assign pending = exp_wr - exp_rd;

  function automatic logic slot_live(logic [ADDR_W-1:0] a);
    return (a < ADDR_W'(CAP)) && live[a];
  endfunction

  function automatic void drop_all();
    alloc_ptr = 0;
    elems     = 0;
    for (int i = 0; i < CAP; i++) live[i] = 1'b0;
    next_l[HEAD] = TAIL;
    prev_l[TAIL] = HEAD;
  endfunction

  // apply one request to the shadow list and return the response it yields
  function automatic rsp_t apply_request(req_t r);
    rsp_t              o;
    logic [ADDR_W-1:0] p, n, node;
    logic              show;
    o    = '0;
    show = 1'b0;
    node = '0;
    case (r.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
        if (r.command == CMD_INSERT && r.node_addr != HEAD && !slot_live(r.node_addr)) begin
          o.status = ST_BAD;
        end else if (alloc_ptr >= CAP) begin
          o.status = ST_FULL;
        end else begin
          if (r.command == CMD_PUSH_BACK) begin
            n = TAIL;
            p = prev_l[TAIL];
          end else if (r.command == CMD_PUSH_FRONT) begin
            p = HEAD;
            n = next_l[HEAD];
          end else begin
            p = r.node_addr;
            n = next_l[p];
          end
          node           = ADDR_W'(alloc_ptr);
          node_val[node] = r.value;
          prev_l[node]   = p;
          next_l[node]   = n;
          next_l[p]      = node;
          prev_l[n]      = node;
          live[node]     = 1'b1;
          alloc_ptr++;
          elems++;
          o.result_addr = node;
          show = 1'b1;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT, CMD_ERASE: begin
        if (elems == 0) begin
          o.status = ST_EMPTY;
        end else if (r.command == CMD_ERASE && !slot_live(r.node_addr)) begin
          o.status = ST_BAD;
        end else begin
          if (r.command == CMD_POP_BACK) node = prev_l[TAIL];
          else if (r.command == CMD_POP_FRONT) node = next_l[HEAD];
          else node = r.node_addr;
          p = prev_l[node];
          n = next_l[node];
          next_l[p]  = n;
          prev_l[n]  = p;
          live[node] = 1'b0;
          elems--;
          o.result_addr = p;
          show = 1'b1;
        end
      end
      CMD_READ: begin
        if (!slot_live(r.node_addr)) begin
          o.status = ST_BAD;
        end else begin
          node = r.node_addr;
          o.result_addr = node;
          show = 1'b1;
        end
      end
      CMD_FIND: begin
        if (elems == 0) begin
          o.status = ST_EMPTY;
        end else if (int'(r.position) >= elems) begin
          o.status = ST_BAD;
        end else begin
          node = next_l[HEAD];
          for (int i = 0; i < int'(r.position) && node < TAIL; i++) node = next_l[node];
          o.result_addr = node;
          show = node < HEAD;
        end
      end
      CMD_CLEAR: drop_all();
      default: ;
    endcase
    if (show) begin
      o.read_value = node_val[node];
      o.prev_addr  = prev_l[node];
      o.next_addr  = next_l[node];
    end
    o.count    = ADDR_W'(elems);
    o.is_empty = (elems == 0);
    return o;
  endfunction

  // predict on each accepted request, compare on each accepted response
  always @(posedge clk) begin
    rsp_t want, got;
    if (rst) begin
      for (int i = 0; i < CAP + 2; i++) begin
        prev_l[i] = '0;
        next_l[i] = '0;
      end
      drop_all();
      exp_wr = 0;
      exp_rd = 0;
      errors = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (exp_wr == exp_rd) begin
          errors++;
          if (errors <= 10) $display("response with nothing outstanding: %p", got);
        end else begin
          want = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected st=%0d addr=%0d val=%0d prev=%0d next=%0d cnt=%0d emp=%0b",
                       want.status, want.result_addr, want.read_value, want.prev_addr,
                       want.next_addr, want.count, want.is_empty);
              $display("  actual   st=%0d addr=%0d val=%0d prev=%0d next=%0d cnt=%0d emp=%0b",
                       got.status, got.result_addr, got.read_value, got.prev_addr,
                       got.next_addr, got.count, got.is_empty);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        exp_buf[exp_wr % EXP_DEPTH] = apply_request(req_ch.data);
        exp_wr++;
      end
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the list core: directed corner requests, then random
// request mixes under several idle and stall patterns, and a long response
// hold-off; checking is done by adll_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import adll_pkg::*;

  localparam int CAP = 1024;

  logic clk;
  logic rst;
  int   errors;
  int   pending;

  // traffic shaping
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int issued_nodes = 0;

  adll_stream_if #(.T(req_t)) req_ch ();
  adll_stream_if #(.T(rsp_t)) rsp_ch ();

  array_doubly_linked_list_core #(
    .LIST_CAPACITY(CAP),
    .VALUE_WIDTH  (DATA_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  adll_checker #(.CAP(CAP)) i_checker (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // response side: random stalls plus an optional long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one request and hold it until the core takes it
  task automatic send(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [POS_W-1:0] pos,
                      logic signed [DATA_W-1:0] val);
    req_t r;
    r.command   = cmd;
    r.node_addr = addr;
    r.position  = pos;
    r.value     = val;
    if ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (cmd == CMD_CLEAR) issued_nodes = 0;
    else if (cmd inside {CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT} && issued_nodes < CAP)
      issued_nodes++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return ADDR_W'($urandom_range(0, (issued_nodes > 0) ? issued_nodes - 1 : 0));
    if (roll < 82) return ADDR_W'(CAP);
    if (roll < 88) return ADDR_W'(CAP + 1);
    return ADDR_W'($urandom);
  endfunction

  // one random request, mostly well formed
  task automatic random_request();
    int                roll;
    cmd_t              cmd;
    logic [POS_W-1:0]  pos;
    roll = $urandom_range(99);
    if (roll < 22) cmd = CMD_PUSH_BACK;
    else if (roll < 34) cmd = CMD_PUSH_FRONT;
    else if (roll < 46) cmd = CMD_INSERT;
    else if (roll < 54) cmd = CMD_POP_BACK;
    else if (roll < 62) cmd = CMD_POP_FRONT;
    else if (roll < 72) cmd = CMD_ERASE;
    else if (roll < 84) cmd = CMD_READ;
    else if (roll < 95) cmd = CMD_FIND;
    else if (roll < 97) cmd = CMD_CLEAR;
    else cmd = cmd_t'(4'(CMD_CLEAR) + 4'($urandom_range(1, 7)));
    // long walks are rare
    pos = ($urandom_range(99) < 95) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom);
    send(cmd, pick_addr(), pos, $urandom);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list errors, bad targets, extremes, walks, clear
    send(CMD_POP_BACK, '0, '0, '0);
    send(CMD_POP_FRONT, '0, '0, '0);
    send(CMD_ERASE, '0, '0, '0);
    send(CMD_FIND, '0, '0, '0);
    send(CMD_READ, ADDR_W'(CAP), '0, '0);
    send(CMD_READ, '0, '0, '0);
    send(CMD_INSERT, ADDR_W'(CAP + 1), '0, 32'sd5);
    send(CMD_INSERT, '0, '0, 32'sd6);
    send(CMD_PUSH_BACK, '0, '0, 32'sh7fffffff);
    send(CMD_PUSH_FRONT, '0, '0, 32'sh80000000);
    send(CMD_INSERT, ADDR_W'(CAP), '0, -32'sd1);
    send(CMD_INSERT, '0, '0, '0);
    send(CMD_READ, '0, '0, '0);
    send(CMD_READ, ADDR_W'(CAP + 1), '0, '0);
    send(CMD_FIND, '0, '0, '0);
    send(CMD_FIND, '0, POS_W'(3), '0);
    send(CMD_FIND, '0, '1, '0);
    send(CMD_ERASE, ADDR_W'(2), '0, '0);
    send(CMD_ERASE, ADDR_W'(2), '0, '0);
    send(CMD_POP_BACK, '0, '0, '0);
    send(CMD_POP_FRONT, '0, '0, '0);
    send(cmd_t'(4'hf), '1, '1, '1);
    send(CMD_CLEAR, '0, '0, '0);
    send(CMD_READ, ADDR_W'(1), '0, '0);
    send(CMD_PUSH_BACK, '1, '1, -32'sd1);

    // random mixes under each idle and stall pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      repeat (100) random_request();
    end

    // long response hold-off while requests keep coming
    idle_pct    = 0;
    stall_pct   = 12;
    hold_cycles = 300;
    repeat (25) random_request();

    drain();
    if (errors == 0) $display("array_doubly_linked_list_core regression: pass");
    else $display("array_doubly_linked_list_core regression: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("array_doubly_linked_list_core regression: fail");
    $finish;
  end

endmodule
